[rtl/core/lmce_pkg.sv]
// lmce_pkg: shared types and constants for the lz match code encoder
// holds field widths, escape code bases, short distance bases and the result record
// no dependencies
package lmce_pkg;

  // history ring and distance field
  localparam int HISTORY_DEPTH         = 4;
  localparam int HIST_PTR_W            = $clog2(HISTORY_DEPTH);
  localparam int DISTANCE_BITS_DEFAULT = 20;

  // configuration register
  localparam int          IMAGE_WIDTH_W     = 16;
  localparam logic [15:0] IMAGE_WIDTH_RESET = 16'd1024;

  // input field widths
  localparam int LENGTH_W = 9;

  // output field widths
  localparam int ESC_W    = 5;
  localparam int CODE_W   = 8;
  localparam int EXTRA_W  = 16;
  localparam int XCOUNT_W = 5;

  // escape codes
  localparam logic [ESC_W-1:0] ESC_DIST_ONE   = 5'd4;
  localparam int               ESC_SMALL_ADD  = 2;   // distances 3..6 give 5..8
  localparam int               ESC_WIDTH_BASE = 9;   // distances near one row
  localparam int               ESC_LEN_BASE   = 14;  // short lengths start here
  localparam logic [ESC_W-1:0] ESC_LEN_SYM    = 5'd22;
  localparam logic [ESC_W-1:0] ESC_LONG_ADD   = 5'd9;
  localparam int               MAX_INLINE_LEN = 9;

  // short distance symbol bases
  localparam int SD_SMALL_SUB   = 6;
  localparam int SD_BELOW_BASE  = 11;
  localparam int SD_ABOVE_BASE  = 25;
  localparam int SD_ROW_BASE    = 39;
  localparam int SD_ROW_STRIDE  = 17;
  localparam int SD_SMALL_LIMIT = 16;

  // long distance split
  localparam int LD_BIAS  = 17;
  localparam int LD_SHIFT = 5;

  // first and last row multiple with a short code
  localparam int ROW_FIRST = 2;
  localparam int ROW_LAST  = 8;

  // one result item
  typedef struct packed {
    logic [XCOUNT_W-1:0] extra_count;
    logic [EXTRA_W-1:0]  extra_value;
    logic [CODE_W-1:0]   far_sym;
    logic                has_far;
    logic [CODE_W-1:0]   near_sym;
    logic                has_near;
    logic [CODE_W-1:0]   len_sym;
    logic                has_len;
    logic [ESC_W-1:0]    esc_sym;
  } result_t;

  localparam int RESULT_W     = $bits(result_t);
  localparam int OUT_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

endpackage

[rtl/core/lz_match_code_encoder_top.sv]
// lz_match_code_encoder_top: each match passes the input register, then the result
// register; one match per cycle back to back while the result channel does not stall,
// since the input register refills in the edge that moves its item on; the only loop
// is the four-entry history ring, updated in that same edge
// rst_n is synchronous and active low: clears valids, history, pointer and sets
// image_width to 1024
// depends on lmce_pkg
module lz_match_code_encoder_top #(
  parameter int  DISTANCE_BITS = lmce_pkg::DISTANCE_BITS_DEFAULT,
  localparam int IN_TDATA_W    = ((DISTANCE_BITS + lmce_pkg::LENGTH_W + 1 + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration: image_width
  input  logic                                 cfg_we,
  input  logic [lmce_pkg::IMAGE_WIDTH_W-1:0]   cfg_wdata,
  // input channel; tdata: match_distance, match_length, remember, zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [IN_TDATA_W-1:0]                in_tdata,
  // result channel; tdata: escape symbol, length flag, length symbol, near flag,
  // near symbol, far flag, far symbol, extra_value, extra_count, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lmce_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import lmce_pkg::*;

  localparam int DB = DISTANCE_BITS;
  // signed width that holds distances and eight rows of the widest image
  localparam int SW = ((DB > 20) ? DB : 20) + 2;
  localparam int QW = DB - LD_SHIFT + 1;
  localparam int NROW = ROW_LAST - ROW_FIRST + 1;

  // ---------------------------------------------------------------- registers
  logic [IMAGE_WIDTH_W-1:0] image_width_r;
  logic [DB-1:0]            recent_r [HISTORY_DEPTH];
  logic [HIST_PTR_W-1:0]    hist_ptr_r;

  logic                in_valid_r;
  logic [DB-1:0]       dist_r;
  logic [LENGTH_W-1:0] len_r;
  logic                keep_r;

  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;

  logic advance;
  logic take_in;

  // stage handshake: input register refills whenever its item moves on
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign take_in   = in_tvalid && in_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= IMAGE_WIDTH_RESET;
    end else if (cfg_we) begin
      image_width_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      dist_r <= in_tdata[DB-1:0];
      len_r  <= in_tdata[DB +: LENGTH_W];
      keep_r <= in_tdata[DB + LENGTH_W];
    end
  end

  // history ring, pushed as the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_ptr_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        recent_r[i] <= '0;
      end
    end else if (in_valid_r && advance && keep_r) begin
      recent_r[hist_ptr_r] <= dist_r;
      hist_ptr_r           <= hist_ptr_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------- encoding
  logic signed [SW-1:0] d_s;
  logic signed [SW-1:0] w_s;
  logic signed [SW-1:0] wdiff;
  logic signed [SW-1:0] row_diff [NROW];
  logic [NROW-1:0]      row_hit;

  logic [HISTORY_DEPTH-1:0] hist_hit;
  logic [HIST_PTR_W-1:0]    slot [HISTORY_DEPTH];

  logic [DB-1:0]  dd;
  logic [QW-1:0]  q;
  logic [4:0]     eb;
  logic [DB-1:0]  c0;
  logic [DB-1:0]  r;
  logic [DB-1:0]  r_hi;
  logic [DB-1:0]  x_mask;

  assign d_s   = $signed(SW'(dist_r));
  assign w_s   = $signed(SW'(image_width_r));
  assign wdiff = d_s - w_s;

  // history compare, newest first
  always_comb begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      slot[k]     = hist_ptr_r - HIST_PTR_W'(k + 1);
      hist_hit[k] = (dist_r == recent_r[slot[k]]);
    end
  end

  // row multiple windows, each d - y*w within -8..8
  always_comb begin
    for (int y = 0; y < NROW; y++) begin
      row_diff[y] = d_s - SW'(y + ROW_FIRST) * w_s;
      row_hit[y]  = (row_diff[y] >= -SW'(8)) && (row_diff[y] <= SW'(8));
    end
  end

  // long distance split by highest set bit of the scaled distance
  always_comb begin
    dd = dist_r - DB'(LD_BIAS);
    q  = QW'(dd >> LD_SHIFT) + QW'(1);
    eb = 5'd1;
    for (int b = 1; b < QW; b++) begin
      if (q[b]) begin
        eb = 5'(b + 1);
      end
    end
    c0     = ((DB'(1) << (eb - 5'd1)) - DB'(1)) << LD_SHIFT;
    r      = dd - c0;
    r_hi   = r >> eb;
    x_mask = (DB'(1) << eb) - DB'(1);
  end

  // symbol selection in priority order
  always_comb begin
    logic found;
    logic row_found;
    res_nxt             = '0;
    res_nxt.has_len     = 1'b1;
    res_nxt.len_sym     = CODE_W'(len_r - LENGTH_W'(2));
    found               = 1'b0;
    row_found           = 1'b0;

    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (!found && hist_hit[k]) begin
        res_nxt.esc_sym = ESC_W'(k);
        found           = 1'b1;
      end
    end

    priority if (found) begin
      // recent distance escape already set
    end else if (dist_r == DB'(1)) begin
      res_nxt.esc_sym = ESC_DIST_ONE;
    end else if (dist_r >= DB'(3) && dist_r <= DB'(6)) begin
      res_nxt.esc_sym = ESC_W'(dist_r) + ESC_W'(ESC_SMALL_ADD);
    end else if (wdiff >= -SW'(2) && wdiff <= SW'(2)) begin
      res_nxt.esc_sym = ESC_W'(wdiff + SW'(ESC_WIDTH_BASE + 2));
    end else begin
      // length-bearing escape
      if (len_r <= LENGTH_W'(MAX_INLINE_LEN)) begin
        res_nxt.has_len = 1'b0;
        res_nxt.esc_sym = ESC_W'(len_r) + ESC_W'(ESC_LEN_BASE - 2);
      end else begin
        res_nxt.has_len = 1'b1;
        res_nxt.esc_sym = ESC_LEN_SYM;
      end
      res_nxt.has_near = 1'b1;

      priority if (dist_r == DB'(2)) begin
        res_nxt.near_sym = '0;
      end else if (dist_r <= DB'(SD_SMALL_LIMIT)) begin
        res_nxt.near_sym = CODE_W'(dist_r) - CODE_W'(SD_SMALL_SUB);
      end else if (wdiff >= -SW'(16) && wdiff <= -SW'(3)) begin
        res_nxt.near_sym = CODE_W'(wdiff + SW'(SD_BELOW_BASE + 16));
      end else if (wdiff >= SW'(3) && wdiff <= SW'(16)) begin
        res_nxt.near_sym = CODE_W'(wdiff + SW'(SD_ABOVE_BASE - 3));
      end else begin
        for (int y = 0; y < NROW; y++) begin
          if (!row_found && row_hit[y]) begin
            res_nxt.near_sym = CODE_W'(row_diff[y] + SW'(SD_ROW_BASE + 8 + y * SD_ROW_STRIDE));
            row_found        = 1'b1;
          end
        end
        if (!row_found) begin
          // long distance symbol with extra bits
          res_nxt.esc_sym     = res_nxt.esc_sym + ESC_LONG_ADD;
          res_nxt.has_near    = 1'b0;
          res_nxt.near_sym    = '0;
          res_nxt.has_far     = 1'b1;
          res_nxt.far_sym     = CODE_W'({eb - 5'd1, 4'd0}) + CODE_W'(r_hi);
          res_nxt.extra_value = EXTRA_W'(r & x_mask);
          res_nxt.extra_count = XCOUNT_W'(eb);
        end
      end
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(res_r);

endmodule

[tb/lmce_match_checker.sv]
// lmce_match_checker: watches the config, input and result channels of the lz match
// code encoder, predicts each result from its own copy of the history and image width,
// and compares every field; depends on lmce_pkg for the result record and field widths
module lmce_match_checker #(
  parameter int DIST_W = lmce_pkg::DISTANCE_BITS_DEFAULT,
  parameter int IN_W   = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lmce_pkg::IMAGE_WIDTH_W-1:0]  cfg_wdata,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  // fields: match_distance, match_length, remember, zero pad
  input  logic [IN_W-1:0]                     in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  // fields: escape symbol, length flag, length symbol, near flag, near symbol,
  // far flag, far symbol, extra_value, extra_count, zero pad
  input  logic [lmce_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output int                                  mismatch_count,
  output int                                  pending_codes
);
  timeunit 1ns;
  timeprecision 1ps;
  import lmce_pkg::*;

  // escape symbols
  localparam int EscDistOne    = 4;
  localparam int EscSmallOfs   = 2;
  localparam int EscRowBase    = 9;
  localparam int EscInlineBase = 14;
  localparam int EscLenSymbol  = 22;
  localparam int EscFarAdd     = 9;
  localparam int InlineLenMax  = 9;

  // short distance symbol layout
  localparam int ShortNearSub  = 6;
  localparam int ShortNearMax  = 16;
  localparam int ShortBelowSym = 11;
  localparam int ShortAboveSym = 25;
  localparam int ShortRowSym   = 39;
  localparam int ShortRowStep  = 17;
  localparam int RowFirst      = 2;
  localparam int RowLast       = 8;

  // long distance split
  localparam int FarBias  = 17;
  localparam int FarShift = 5;

  localparam logic [IMAGE_WIDTH_W-1:0] WidthAtReset = 16'd1024;

  logic [DIST_W-1:0]        recent_dist [HISTORY_DEPTH];
  logic [HIST_PTR_W-1:0]    next_slot;
  logic [IMAGE_WIDTH_W-1:0] row_width;
  result_t                  expected_codes [$];
  int                       errors = 0;

  // symbol set for one match, against the current history and width
  function automatic result_t encode_match(logic [DIST_W-1:0] mdist,
                                           logic [LENGTH_W-1:0] len);
    result_t               r;
    logic                  hit;
    logic                  row_hit;
    logic [HIST_PTR_W-1:0] slot;
    logic [LENGTH_W-1:0]   len_m2;
    logic [ESC_W-1:0]      esc;
    longint                d;
    longint                w;
    longint                lo;
    longint unsigned       dd;
    longint unsigned       bucket;
    longint unsigned       rem;
    int unsigned           eb;
    r       = '0;
    hit     = 1'b0;
    row_hit = 1'b0;
    d       = mdist;
    w       = row_width;
    len_m2  = len - LENGTH_W'(2);
    r.len_sym = len_m2[CODE_W-1:0];
    r.has_len = 1'b1;

    // recent distances, newest first
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      slot = next_slot - HIST_PTR_W'(1) - HIST_PTR_W'(k);
      if (!hit && mdist == recent_dist[slot]) begin
        r.esc_sym = ESC_W'(k);
        hit = 1'b1;
      end
    end
    if (!hit && mdist == 1) begin
      r.esc_sym = ESC_W'(EscDistOne);
      hit = 1'b1;
    end
    if (!hit && mdist >= 3 && mdist <= 6) begin
      r.esc_sym = ESC_W'(mdist + EscSmallOfs);
      hit = 1'b1;
    end
    if (!hit && d >= w - 2 && d <= w + 2) begin
      r.esc_sym = ESC_W'(d - (w - 2) + EscRowBase);
      hit = 1'b1;
    end

    // length-bearing escape with a short or long distance
    if (!hit) begin
      if (len <= InlineLenMax) begin
        r.has_len = 1'b0;
        esc = ESC_W'(EscInlineBase + len - 2);
      end else begin
        esc = ESC_W'(EscLenSymbol);
      end
      r.has_near = 1'b1;
      if (mdist == 2) begin
        r.near_sym = '0;
      end else if (mdist <= ShortNearMax) begin
        r.near_sym = CODE_W'(mdist - ShortNearSub);
      end else if (d >= w - 16 && d <= w - 3) begin
        r.near_sym = CODE_W'(ShortBelowSym + d - (w - 16));
      end else if (d >= w + 3 && d <= w + 16) begin
        r.near_sym = CODE_W'(ShortAboveSym + d - (w + 3));
      end else begin
        for (int y = RowFirst; y <= RowLast; y++) begin
          lo = y * w - 8;
          if (!row_hit && d >= lo && d <= lo + 16) begin
            r.near_sym = CODE_W'(ShortRowSym + (y - RowFirst) * ShortRowStep + (d - lo));
            row_hit = 1'b1;
          end
        end
        // long distance: bucket by highest set bit of the shifted remainder
        if (!row_hit) begin
          dd     = d - FarBias;
          bucket = (dd >> FarShift) + 1;
          eb     = 0;
          for (int i = 0; i < 64; i++) begin
            if (bucket[i]) eb = i + 1;
          end
          rem           = dd - ((((64'd1 << (eb - 1)) - 1)) << FarShift);
          esc           = esc + ESC_W'(EscFarAdd);
          r.has_near    = 1'b0;
          r.near_sym    = '0;
          r.has_far     = 1'b1;
          r.far_sym     = CODE_W'((64'(eb - 1) << 4) + (rem >> eb));
          r.extra_value = EXTRA_W'(rem & ((64'd1 << eb) - 1));
          r.extra_count = XCOUNT_W'(eb);
        end
      end
      r.esc_sym = esc;
    end
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      if (errors < 10)
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
      errors++;
    end
  endtask

  // follow each transfer on every channel
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    logic [DIST_W-1:0]   mdist;
    logic [LENGTH_W-1:0] len;
    logic                keep;
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) recent_dist[i] = '0;
      next_slot = '0;
      row_width = WidthAtReset;
      expected_codes.delete();
    end else begin
      // result side: compare against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          if (errors < 10) $display("%0t: result transfer with none expected", $realtime);
          errors++;
        end else begin
          want = expected_codes.pop_front();
          got  = result_t'(out_tdata[RESULT_W-1:0]);
          check_field("escape symbol", want.esc_sym,     got.esc_sym);
          check_field("length flag",   want.has_len,     got.has_len);
          check_field("length symbol", want.len_sym,     got.len_sym);
          check_field("near flag",     want.has_near,    got.has_near);
          check_field("near symbol",   want.near_sym,    got.near_sym);
          check_field("far flag",      want.has_far,     got.has_far);
          check_field("far symbol",    want.far_sym,     got.far_sym);
          check_field("extra_value",   want.extra_value, got.extra_value);
          check_field("extra_count",   want.extra_count, got.extra_count);
        end
      end
      // input side: predict, then push the distance if flagged
      if (in_tvalid && in_tready) begin
        mdist = in_tdata[DIST_W-1:0];
        len   = in_tdata[DIST_W +: LENGTH_W];
        keep  = in_tdata[DIST_W + LENGTH_W];
        expected_codes = {expected_codes, encode_match(mdist, len)};
        if (keep) begin
          recent_dist[next_slot] = mdist;
          next_slot = next_slot + HIST_PTR_W'(1);
        end
      end
      if (cfg_we) row_width = cfg_wdata;
    end
    mismatch_count <= errors;
    pending_codes  <= expected_codes.size();
  end

endmodule

[tb/tb_lz_match_code_encoder_top.sv]
// tb_lz_match_code_encoder_top: clock, reset and stimulus for the lz match code
// encoder, with random idling on both channels and a final verdict
// depends on lmce_pkg, lz_match_code_encoder_top and lmce_match_checker
module tb_lz_match_code_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIST_W = lmce_pkg::DISTANCE_BITS_DEFAULT;
  localparam int LEN_W  = lmce_pkg::LENGTH_W;
  localparam int IN_W   = ((DIST_W + LEN_W + 1 + 7) / 8) * 8;

  logic                                  clk        = 1'b0;
  logic                                  rst_n      = 1'b0;
  logic                                  cfg_we     = 1'b0;
  logic [lmce_pkg::IMAGE_WIDTH_W-1:0]    cfg_wdata  = '0;
  logic                                  in_tvalid  = 1'b0;
  logic                                  in_tready;
  // fields: match_distance, match_length, remember, zero pad
  logic [IN_W-1:0]                       in_tdata   = '0;
  logic                                  out_tvalid;
  logic                                  out_tready = 1'b0;
  // fields: escape symbol, length flag, length symbol, near flag, near symbol,
  // far flag, far symbol, extra_value, extra_count, zero pad
  logic [lmce_pkg::OUT_TDATA_W-1:0]      out_tdata;

  int mismatch_count;
  int pending_codes;

  // stimulus-side knobs read by the sender and the result sink
  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  int hold_request = 0;

  // distances most recently sent with remember set, for history hits
  logic [DIST_W-1:0] remembered [4] = '{default: '0};
  int                remembered_ptr = 0;
  int                cur_width = 1024;

  lz_match_code_encoder_top #(.DISTANCE_BITS(DIST_W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lmce_match_checker #(.DIST_W(DIST_W), .IN_W(IN_W)) code_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_codes  (pending_codes)
  );

  always #5 clk = ~clk;

  // result sink: random stall bursts plus one long hold-off on request
  initial begin : result_sink
    int idle_left;
    int hold_left;
    bit hold_taken;
    idle_left  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0 && !hold_taken) begin
        hold_left  = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        idle_left = $urandom_range(0, 13);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one match transfer; valid stays high into the next call
  task automatic send_match(logic [DIST_W-1:0] mdist, logic [LEN_W-1:0] len, logic keep);
    int gap;
    if (tx_idle_on && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({keep, len, mdist});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (keep) begin
      remembered[remembered_ptr] = mdist;
      remembered_ptr = (remembered_ptr + 1) % 4;
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_codes != 0);
  endtask

  task automatic set_width(int width);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= lmce_pkg::IMAGE_WIDTH_W'(width);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_width = width;
  endtask

  // random match aimed at history, row windows and long buckets
  task automatic random_match();
    logic [DIST_W-1:0] mdist;
    logic [LEN_W-1:0]  len;
    int                y;
    case ($urandom_range(0, 9))
      0: mdist = remembered[$urandom_range(0, 3)];
      1: mdist = DIST_W'($urandom_range(0, 20));
      2: mdist = DIST_W'(cur_width + $urandom_range(0, 40) - 20);
      3, 4: begin
        y     = $urandom_range(1, 9);
        mdist = DIST_W'(y * cur_width + $urandom_range(0, 20) - 10);
      end
      5: mdist = DIST_W'((1 << $urandom_range(5, 19)) + $urandom_range(0, 40) - 20);
      default: mdist = DIST_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: len = LEN_W'($urandom_range(0, 511));
      1: len = LEN_W'($urandom_range(2, 9));
      default: len = LEN_W'($urandom_range(2, 256));
    endcase
    send_match(mdist, len, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int widths [8];
    widths = '{0, 1, 2, 65535, 5, 4096, 333, 1024};
    widths[6] = $urandom_range(1, 65535);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed matches at the reset width
    send_match(20'd0, 9'd2, 1'b0);        // zero distance hits an empty history slot
    send_match(20'd1, 9'd2, 1'b0);
    send_match(20'd3, 9'd256, 1'b0);
    send_match(20'd6, 9'd9, 1'b0);
    send_match(20'd1022, 9'd10, 1'b0);    // one row, both window edges
    send_match(20'd1026, 9'd200, 1'b0);
    send_match(20'd2, 9'd2, 1'b0);
    send_match(20'd16, 9'd9, 1'b0);
    send_match(20'd1008, 9'd100, 1'b0);   // just below and above one row
    send_match(20'd1021, 9'd4, 1'b0);
    send_match(20'd1027, 9'd5, 1'b0);
    send_match(20'd1040, 9'd3, 1'b0);
    send_match(20'd2040, 9'd50, 1'b0);    // first and last row multiples
    send_match(20'd8200, 9'd60, 1'b0);
    send_match(20'd17, 9'd10, 1'b0);      // smallest and largest long distance
    send_match(20'hFFFFF, 9'd2, 1'b0);
    send_match(20'd100, 9'd0, 1'b0);      // lengths outside the normal range
    send_match(20'd5000, 9'd1, 1'b0);
    send_match(20'd300, 9'd511, 1'b0);
    send_match(20'd500, 9'd20, 1'b1);     // fill the history
    send_match(20'd600, 9'd20, 1'b1);
    send_match(20'd700, 9'd20, 1'b1);
    send_match(20'd800, 9'd20, 1'b1);
    send_match(20'd800, 9'd30, 1'b0);
    send_match(20'd500, 9'd30, 1'b1);
    send_match(20'd0, 9'd5, 1'b0);        // zero distance on the short path

    // random phases, one width each; the last one runs without idling
    for (int p = 0; p < 8; p++) begin
      set_width(widths[p]);
      for (int i = 0; i < 94; i++) begin
        if (i % 20 == 0) begin
          tx_idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
          rx_idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
        end
        // long receiver hold-off while the sender keeps offering
        if (p == 3 && i == 0) begin
          hold_request = 80;
          tx_idle_on   = 1'b0;
        end
        random_match();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lz_match_code_encoder_top verification clean");
    end else begin
      $display("lz_match_code_encoder_top verification failed");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("lz_match_code_encoder_top verification failed");
    $finish;
  end

endmodule
